FILE: rtl/oberon_token_lexer_assert.svh
// Assertion macros for the token lexer
`ifndef OBERON_TOKEN_LEXER_ASSERT_SVH
`define OBERON_TOKEN_LEXER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define OTL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset
`define OTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/otl_pkg.sv
// ----------------------------------------------------------------------------
// otl_pkg
// Shared types and constants of the token lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package otl_pkg;
  localparam int POS_BITS = 16;
  localparam int LEX_CAP  = 255;
  localparam int KW_DEPTH = 9;
  localparam int KW_COUNT = 41;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_OPER
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_COLON, OP_DOT, OP_GT, OP_LT
  } op_t;

  localparam logic [6:0] K_END = 7'd0, K_UNKNOWN = 7'd1, K_UNTERM = 7'd2,
    K_IDENT = 7'd3, K_INT = 7'd4, K_REAL = 7'd5, K_STRING = 7'd6, K_KW0 = 7'd7,
    K_BECOMES = 7'd52, K_COLON = 7'd53, K_UPTO = 7'd62, K_DOT = 7'd63,
    K_GEQ = 7'd68, K_GT = 7'd69, K_LEQ = 7'd70, K_LT = 7'd71;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
  } token_t;

  typedef logic [KW_DEPTH*8-1:0] kw_word_t;

  // Keywords left-aligned, zero-padded; length computed from the text by kw_len
  function automatic kw_word_t kw_text(input int k);
    case (k)
      0: return {"ARRAY", 32'd0};       1: return {"BEGIN", 32'd0};
      2: return {"BY", 56'd0};          3: return {"CASE", 40'd0};
      4: return {"CONST", 32'd0};       5: return {"DIV", 48'd0};
      6: return {"DO", 56'd0};          7: return {"ELSE", 40'd0};
      8: return {"ELSIF", 32'd0};       9: return {"END", 48'd0};
      10: return {"EXIT", 40'd0};       11: return {"FOR", 48'd0};
      12: return {"IF", 56'd0};         13: return {"IMPORT", 24'd0};
      14: return {"IN", 56'd0};         15: return {"IS", 56'd0};
      16: return {"LOOP", 40'd0};       17: return {"MOD", 48'd0};
      18: return {"MODULE", 24'd0};     19: return {"NIL", 48'd0};
      20: return {"OF", 56'd0};         21: return {"OR", 56'd0};
      22: return {"POINTER", 16'd0};    23: return {"PROCEDURE"};
      24: return {"RECORD", 24'd0};     25: return {"REPEAT", 24'd0};
      26: return {"RETURN", 24'd0};     27: return {"THEN", 40'd0};
      28: return {"TO", 56'd0};         29: return {"TYPE", 40'd0};
      30: return {"UNTIL", 32'd0};      31: return {"VAR", 48'd0};
      32: return {"WHILE", 32'd0};      33: return {"WITH", 40'd0};
      34: return {"BOOLEAN", 16'd0};    35: return {"CHAR", 40'd0};
      36: return {"FALSE", 32'd0};      37: return {"INTEGER", 16'd0};
      38: return {"NEW", 48'd0};        39: return {"REAL", 40'd0};
      40: return {"TRUE", 40'd0};
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    kw_word_t t;
    logic [3:0] n;
    t = kw_text(k);
    n = '0;
    for (int i = 0; i < KW_DEPTH; i++) begin
      if (t[(KW_DEPTH-1-i)*8 +: 8] != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/otl_if.sv
// ----------------------------------------------------------------------------
// otl_in_if / otl_out_if
// Valid/ready channels of the token lexer.
// ----------------------------------------------------------------------------
`default_nettype none
interface otl_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] char_code;
  logic        end_of_input;
  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface otl_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [7:0] token_length;
  logic       last_of_run;
  modport source (output valid, token_kind, token_line, token_column, token_length,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_line, token_column, token_length,
                last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/otl_kw_match.sv
// ----------------------------------------------------------------------------
// otl_kw_match
// Classifies a finished identifier as keyword or plain identifier.
// ----------------------------------------------------------------------------
`default_nettype none
module otl_kw_match (
  input  wire otl_pkg::kw_word_t kw_buf,
  input  wire logic [7:0]        lex_len,
  output logic [6:0]             kind
);
  import otl_pkg::*;

  // Compare against every keyword in parallel; at most one matches
  always_comb begin
    kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (lex_len == {4'd0, kw_len(k)} &&
          (kw_buf == kw_text(k))) kind = K_KW0 + 7'(k);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/oberon_token_lexer.sv
// Output: a token is registered in the result buffer in the cycle after the item that ends it.
// Throughput: one character per cycle while the output takes tokens; an item causing two
// tokens holds input while the second token drains from the two-entry result buffer.
// Reset: synchronous active-low rst_n; idle mode, line 1, column 0, buffer empty.
// ----------------------------------------------------------------------------
// oberon_token_lexer
// Streaming scanner: characters in, tokens with kind and position out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "oberon_token_lexer_assert.svh"
module oberon_token_lexer (
  input wire logic clk,
  input wire logic rst_n,
  otl_in_if.sink   in_ch,
  otl_out_if.source out_ch
);
  import otl_pkg::*;

  // Scanner state
  mode_t mode_r, mode_nxt;
  op_t   op_r, op_nxt;
  kw_word_t kw_r, kw_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic dot_r, dot_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt, col_r, col_nxt, sl_r, sl_nxt, sc_r, sc_nxt;

  // Result buffer: two slots
  token_t     q_tok_r [2];
  token_t     q_tok_nxt [2];
  logic       q_last_r [2];
  logic       q_last_nxt [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;

  logic [20:0] c;
  logic eoi, acc;
  logic is_let, is_dig, is_sp, is_q;
  logic [6:0] id_kind, single_kind;
  logic flush_now, begin_now;
  logic [6:0] b_kind;
  logic e1_v, e2_v;
  token_t e1, e2;
  logic [1:0] n_emit;
  logic pop;

  assign c   = in_ch.char_code;
  assign eoi = in_ch.end_of_input;
  // Accept when two slots will be free after this cycle's pop
  assign pop = (q_cnt_r != 2'd0) && out_ch.ready;
  assign in_ch.ready = (q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;

  assign is_let = (c >= 21'd65 && c <= 21'd90) || (c >= 21'd97 && c <= 21'd122) || c == 21'd95;
  assign is_dig = c >= 21'd48 && c <= 21'd57;
  assign is_sp  = (c >= 21'd9 && c <= 21'd13) || c == 21'd32;
  assign is_q   = c == 21'd39;

  otl_kw_match u_kw (.kw_buf(kw_r), .lex_len(cnt_r), .kind(id_kind));

  always_comb begin
    case (op_r)
      OP_COLON: single_kind = K_COLON;
      OP_DOT:   single_kind = K_DOT;
      OP_GT:    single_kind = K_GT;
      default:  single_kind = K_LT;
    endcase
  end

  // Kind of a single-character token started here
  always_comb begin
    case (c)
      21'd43: b_kind = 7'd48;   21'd45: b_kind = 7'd49;
      21'd42: b_kind = 7'd50;   21'd47: b_kind = 7'd51;
      21'd59: b_kind = 7'd54;   21'd44: b_kind = 7'd55;
      21'd40: b_kind = 7'd56;   21'd41: b_kind = 7'd57;
      21'd91: b_kind = 7'd58;   21'd93: b_kind = 7'd59;
      21'd123: b_kind = 7'd60;  21'd125: b_kind = 7'd61;
      21'd38: b_kind = 7'd64;   21'd94: b_kind = 7'd65;
      21'd124: b_kind = 7'd66;  21'd61: b_kind = 7'd67;
      21'd35: b_kind = 7'd72;   21'd126: b_kind = 7'd73;
      default: b_kind = K_UNKNOWN;
    endcase
  end

  // Next scanner state and the tokens of this item
  always_comb begin
    logic [6:0] two;
    mode_nxt = mode_r; op_nxt = op_r; kw_nxt = kw_r; cnt_nxt = cnt_r; dot_nxt = dot_r;
    line_nxt = line_r; col_nxt = col_r; sl_nxt = sl_r; sc_nxt = sc_r;
    e1_v = 1'b0; e2_v = 1'b0; e1 = '0; e2 = '0;
    flush_now = 1'b0; begin_now = 1'b0;
    two = '0;
    if (eoi) begin
      flush_now = 1'b1;
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if ((is_let || is_dig) && cnt_r < 8'(LEX_CAP)) begin
            if (cnt_r < 8'(KW_DEPTH))
              kw_nxt[(KW_DEPTH-1-int'(cnt_r[3:0]))*8 +: 8] = c[7:0];
            cnt_nxt = cnt_r + 8'd1;
          end else begin flush_now = 1'b1; begin_now = 1'b1; end
        end
        MODE_NUMBER: begin
          if (cnt_r < 8'(LEX_CAP) && (is_dig || (c == 21'd46 && !dot_r))) begin
            if (c == 21'd46) dot_nxt = 1'b1;
            cnt_nxt = cnt_r + 8'd1;
          end else begin flush_now = 1'b1; begin_now = 1'b1; end
        end
        MODE_STRING: begin
          if (is_q) begin
            e1_v = 1'b1; e1 = '{K_STRING, sl_r, sc_r, cnt_r};
            mode_nxt = MODE_IDLE;
          end else if (cnt_r < 8'(LEX_CAP)) cnt_nxt = cnt_r + 8'd1;
          else begin flush_now = 1'b1; begin_now = 1'b1; end
        end
        MODE_OPER: begin
          if (c == 21'd61 && op_r == OP_COLON) two = K_BECOMES;
          else if (c == 21'd46 && op_r == OP_DOT) two = K_UPTO;
          else if (c == 21'd61 && op_r == OP_GT) two = K_GEQ;
          else if (c == 21'd61 && op_r == OP_LT) two = K_LEQ;
          if (two != 7'd0) begin
            e1_v = 1'b1; e1 = '{two, sl_r, sc_r, 8'd2};
            mode_nxt = MODE_IDLE; op_nxt = OP_NONE;
          end else begin flush_now = 1'b1; begin_now = 1'b1; end
        end
        default: begin mode_nxt = MODE_IDLE; begin_now = 1'b1; end
      endcase
    end

    // Flush the held token
    if (flush_now) begin
      case (mode_r)
        MODE_IDENT:  begin e1_v = 1'b1; e1 = '{id_kind, sl_r, sc_r, cnt_r}; end
        MODE_NUMBER: begin e1_v = 1'b1; e1 = '{dot_r ? K_REAL : K_INT, sl_r, sc_r, cnt_r}; end
        MODE_STRING: begin e1_v = 1'b1; e1 = '{K_UNTERM, sl_r, sc_r, cnt_r}; end
        MODE_OPER:   begin e1_v = 1'b1; e1 = '{single_kind, sl_r, sc_r, 8'd1}; end
        default: ;
      endcase
      mode_nxt = MODE_IDLE; op_nxt = OP_NONE;
    end

    if (eoi) begin
      e2_v = 1'b1; e2 = '{K_END, line_r, col_r, 8'd0};
      line_nxt = 16'd1; col_nxt = '0; sl_nxt = 16'd1; sc_nxt = '0;
      cnt_nxt = '0; dot_nxt = 1'b0;
    end else begin
      // Start a new token on this character
      if (begin_now && !is_sp) begin
        sl_nxt = line_r; sc_nxt = col_r;
        if (is_let) begin
          mode_nxt = MODE_IDENT; kw_nxt[(KW_DEPTH-1)*8 +: 8] = c[7:0]; cnt_nxt = 8'd1;
        end else if (is_dig) begin
          mode_nxt = MODE_NUMBER; cnt_nxt = 8'd1; dot_nxt = 1'b0;
        end else if (is_q) begin
          mode_nxt = MODE_STRING; cnt_nxt = '0;
        end else if (c == 21'd58) begin mode_nxt = MODE_OPER; op_nxt = OP_COLON; end
        else if (c == 21'd46) begin mode_nxt = MODE_OPER; op_nxt = OP_DOT; end
        else if (c == 21'd62) begin mode_nxt = MODE_OPER; op_nxt = OP_GT; end
        else if (c == 21'd60) begin mode_nxt = MODE_OPER; op_nxt = OP_LT; end
        else begin
          e2_v = 1'b1; e2 = '{b_kind, line_r, col_r, 8'd1};
        end
      end
      // Advance position
      if (c == 21'd10) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        col_nxt = '0;
      end else if (col_r != 16'hFFFF) col_nxt = col_r + 16'd1;
    end
    // Clear the rest of the keyword buffer when an identifier starts
    if (mode_nxt == MODE_IDENT && cnt_nxt == 8'd1) kw_nxt[(KW_DEPTH-1)*8-1:0] = '0;
    n_emit = {1'b0, e1_v} + {1'b0, e2_v};
  end

  // Scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; op_r <= OP_NONE; cnt_r <= '0; dot_r <= 1'b0;
      line_r <= 16'd1; col_r <= '0; sl_r <= 16'd1; sc_r <= '0; kw_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt; op_r <= op_nxt; cnt_r <= cnt_nxt; dot_r <= dot_nxt;
      line_r <= line_nxt; col_r <= col_nxt; sl_r <= sl_nxt; sc_r <= sc_nxt; kw_r <= kw_nxt;
    end
  end

  // Result buffer next value: an accepted item always finds slot 0 free
  always_comb begin
    q_tok_nxt[0] = q_tok_r[0]; q_last_nxt[0] = q_last_r[0];
    q_tok_nxt[1] = q_tok_r[1]; q_last_nxt[1] = q_last_r[1];
    if (acc && n_emit != 2'd0) begin
      if (e1_v) begin
        q_tok_nxt[0] = e1; q_last_nxt[0] = !e2_v;
        if (e2_v) begin q_tok_nxt[1] = e2; q_last_nxt[1] = 1'b1; end
      end else begin
        q_tok_nxt[0] = e2; q_last_nxt[0] = 1'b1;
      end
    end else if (pop) begin
      q_tok_nxt[0] = q_tok_r[1]; q_last_nxt[0] = q_last_r[1];
    end
    q_cnt_nxt = q_cnt_r - {1'b0, pop} + (acc ? n_emit : 2'd0);
  end

  // Result buffer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    q_tok_r[0] <= q_tok_nxt[0]; q_last_r[0] <= q_last_nxt[0];
    q_tok_r[1] <= q_tok_nxt[1]; q_last_r[1] <= q_last_nxt[1];
  end

  assign out_ch.valid        = q_cnt_r != 2'd0;
  assign out_ch.token_kind   = q_tok_r[0].kind;
  assign out_ch.token_line   = q_tok_r[0].line;
  assign out_ch.token_column = q_tok_r[0].column;
  assign out_ch.token_length = q_tok_r[0].length;
  assign out_ch.last_of_run  = q_last_r[0];

  `OTL_ASSERT_IMP(a_buf_bound, 1'b1, q_cnt_r != 2'd3, "result buffer overflow")
  `OTL_ASSERT_NEXT(a_eoi_resets, acc && eoi,
    line_r == 16'd1 && col_r == 16'd0 && mode_r == MODE_IDLE,
    "end of input did not restart position")
  `OTL_ASSERT_IMP(a_full_stall, q_cnt_r == 2'd2, !in_ch.ready, "input taken with full buffer")
  `OTL_ASSERT_IMP(a_op_mode, mode_r != MODE_OPER && mode_r != MODE_IDENT,
    op_r == OP_NONE || mode_r == MODE_IDENT, "operator held outside operator mode")
endmodule
`default_nettype wire
